// ----- rtl/ctnc_pkg.sv -----
// ----------------------------------------------------------------------------
// Canonical tetranucleotide counter package
// Shared constants, codes, types and the k-mer to bin table.
// ----------------------------------------------------------------------------
package ctnc_pkg;

   // Field and counter widths.
   localparam int COUNT_W   = 12;
   localparam int COUNT_MAX = 4095;
   localparam int NUM_BINS  = 136;
   localparam int BIN_AW    = $clog2(NUM_BINS);
   localparam int KMER_SPAN = 256;
   localparam int QUOT_W    = 16;
   localparam int STEP_W    = $clog2(QUOT_W);

   // Codes of the kind field.
   localparam logic [1:0] KIND_FEED  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Control states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_FETCH,
      ST_DIVIDE,
      ST_RESPOND
   } state_type;

   // A completed 4-mer from the front end.
   typedef struct packed {
      logic              hit;
      logic [BIN_AW-1:0] bin;
   } kmer_hit_type;

   // Command to the bin store.
   typedef struct packed {
      logic               clear;
      logic               rd_en;
      logic [BIN_AW-1:0]  rd_addr;
      logic               wr_en;
      logic [BIN_AW-1:0]  wr_addr;
      logic [COUNT_W-1:0] wr_data;
   } store_cmd_type;

   // Command to the frequency divider.
   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] numer;
      logic [COUNT_W-1:0] denom;
   } div_cmd_type;

   typedef logic [BIN_AW-1:0] bin_rom_type [KMER_SPAN];

   // Reverse complement of a 4-mer, first base in the high bits.
   function automatic logic [7:0] revcomp4(input logic [7:0] k);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         r = {r[5:0], 2'd3 - k[2*i +: 2]};
      end
      return r;
   endfunction

   function automatic logic [7:0] canon4(input logic [7:0] k);
      logic [7:0] r;
      r = revcomp4(k);
      return (r < k) ? r : k;
   endfunction

   // Table from a raw 4-mer to the bin of its canonical form. Bins are
   // numbered in ascending order of canonical value. Built at elaboration.
   function automatic bin_rom_type build_bin_rom();
      bin_rom_type canon_bin;
      bin_rom_type rom;
      int          n;
      n = 0;
      for (int k = 0; k < KMER_SPAN; k++) begin
         canon_bin[k] = '0;
         if (canon4(8'(k)) == 8'(k)) begin
            canon_bin[k] = BIN_AW'(n);
            n++;
         end
      end
      for (int k = 0; k < KMER_SPAN; k++) begin
         rom[k] = canon_bin[canon4(8'(k))];
      end
      return rom;
   endfunction

   localparam bin_rom_type BIN_ROM = build_bin_rom();

endpackage

// ----- rtl/ctnc_kmer_front.sv -----
// ----------------------------------------------------------------------------
// Canonical tetranucleotide counter front end
// Decodes base characters, keeps the run history and maps each 4-mer to its
// canonical bin.
// ----------------------------------------------------------------------------
module ctnc_kmer_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  feed,
   input  logic                  clear,
   input  logic [7:0]            base_char,
   output ctnc_pkg::kmer_hit_type hit
);

   logic [5:0] recent_ff, recent_in;
   logic [1:0] run_ff, run_in;
   logic [1:0] code;
   logic       base_ok;

   // Decode A, C, G and T in either case; anything else breaks the run.
   always_comb begin
      code    = 2'd0;
      base_ok = 1'b1;
      case (base_char)
         "A", "a": code = 2'd0;
         "C", "c": code = 2'd1;
         "G", "g": code = 2'd2;
         "T", "t": code = 2'd3;
         default:  base_ok = 1'b0;
      endcase
   end

   // A 4-mer completes when three valid bases precede this one.
   assign hit.hit = feed && base_ok && (run_ff == 2'd3);
   assign hit.bin = ctnc_pkg::BIN_ROM[{recent_ff, code}];

   // Next history and run length.
   always_comb begin
      recent_in = recent_ff;
      run_in    = run_ff;
      if (clear) begin
         recent_in = '0;
         run_in    = '0;
      end else if (feed) begin
         if (!base_ok) begin
            run_in = '0;
         end else begin
            recent_in = {recent_ff[3:0], code};
            run_in    = (run_ff == 2'd3) ? run_ff : run_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
         run_ff    <= '0;
      end else begin
         recent_ff <= recent_in;
         run_ff    <= run_in;
      end
   end

endmodule

// ----- rtl/ctnc_bin_store.sv -----
// ----------------------------------------------------------------------------
// Canonical tetranucleotide counter bin store
// One synchronous memory of bin counts with a registered read and a valid bit
// per entry, so that a clear needs no pass over the memory.
// ----------------------------------------------------------------------------
module ctnc_bin_store (
   input  logic                             clock,
   input  logic                             reset,
   input  ctnc_pkg::store_cmd_type          cmd,
   output logic [ctnc_pkg::COUNT_W-1:0]     rd_data
);

   logic [ctnc_pkg::COUNT_W-1:0]  bin_mem_ff [ctnc_pkg::NUM_BINS];
   logic [ctnc_pkg::NUM_BINS-1:0] valid_ff;
   logic [ctnc_pkg::COUNT_W-1:0]  rd_data_ff;
   logic                          rd_valid_ff;

   // Memory array: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         bin_mem_ff[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= bin_mem_ff[cmd.rd_addr];
      end
   end

   // Valid bits: cleared by reset or a new window, set on a write.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            valid_ff[cmd.wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[cmd.rd_addr];
         end
      end
   end

   // An entry never written since the last clear reads as zero.
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/ctnc_divider.sv -----
// ----------------------------------------------------------------------------
// Canonical tetranucleotide counter frequency divider
// Restoring divider, one quotient bit per cycle, for count * 65536 / total
// with saturation and a zero total handled at start.
// ----------------------------------------------------------------------------
module ctnc_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  ctnc_pkg::div_cmd_type           cmd,
   output logic                            done,
   output logic [ctnc_pkg::QUOT_W-1:0]     quotient
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [ctnc_pkg::STEP_W-1:0]   step_ff;
   logic [ctnc_pkg::COUNT_W-1:0]  rem_ff, rem_in;
   logic [ctnc_pkg::COUNT_W-1:0]  denom_ff;
   logic [ctnc_pkg::QUOT_W-1:0]   quot_ff;
   logic [ctnc_pkg::COUNT_W:0]    shifted;
   logic [ctnc_pkg::COUNT_W:0]    diff;
   logic                          fits;
   logic                          early;

   // A zero total or a count at or above the total needs no iteration.
   assign early = (cmd.denom == '0) || (cmd.numer >= cmd.denom);

   // One restoring step; the remainder stays below the divisor.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, denom_ff};
      fits    = (shifted >= {1'b0, denom_ff});
      rem_in  = fits ? diff[ctnc_pkg::COUNT_W-1:0] : shifted[ctnc_pkg::COUNT_W-1:0];
   end

   // Control: busy flag, step counter and done pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            step_ff <= '0;
            busy_ff <= !early;
            done_ff <= early;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == ctnc_pkg::STEP_W'(ctnc_pkg::QUOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         denom_ff <= cmd.denom;
         rem_ff   <= cmd.numer;
         if (cmd.denom == '0) begin
            quot_ff <= '0;
         end else if (cmd.numer >= cmd.denom) begin
            quot_ff <= '1;
         end else begin
            quot_ff <= '0;
         end
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[ctnc_pkg::QUOT_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

   // While iterating, the partial remainder is below the divisor.
   a_rem_below_denom: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < denom_ff))
      else $error("divider remainder reached the divisor");

endmodule

// ----- rtl/canonical_tetranucleotide_counter_unit.sv -----
// ----------------------------------------------------------------------------
// Canonical tetranucleotide counter unit
// Counts canonical 4-mers of a base stream into 136 saturating bins and reads
// out one bin with its total and Q0.16 frequency.
// ----------------------------------------------------------------------------
// The unit takes one beat at a time and stalls its request side until that
// beat is finished. For a base beat that completes a 4-mer, the bin count is
// read from the bin store in the accept cycle and written back incremented
// in the next one, in ST_UPDATE. Any other base beat needs no further state.
// A new-window beat needs none either; the bin store clears through per-entry
// valid bits, with no clearing pass. A read beat holds the unit from accept
// until its response beat is taken, through ST_FETCH, ST_DIVIDE and ST_RESPOND;
// the 16 divider steps are skipped when the total is zero or the count reaches
// the total, and ST_RESPOND waits out response stalls. Kind 3 beats are dropped.
module canonical_tetranucleotide_counter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_base_char,
   input  logic [7:0]  req_bin_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_bin_count,
   output logic [11:0] rsp_total_kmers,
   output logic [15:0] rsp_frequency
);

   ctnc_pkg::state_type          state_ff, state_in;
   logic [ctnc_pkg::COUNT_W-1:0] total_ff, total_in;
   logic [ctnc_pkg::BIN_AW-1:0]  upd_addr_ff;
   logic                         idx_ok_ff;
   logic [ctnc_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [ctnc_pkg::QUOT_W-1:0]  rsp_freq_ff;

   logic                         accept;
   logic                         feed_acc;
   logic                         read_acc;
   logic                         clear_acc;
   logic                         idx_ok;
   logic [ctnc_pkg::COUNT_W-1:0] rd_data;
   logic [ctnc_pkg::COUNT_W-1:0] fetch_count;
   logic                         div_done;
   logic [ctnc_pkg::QUOT_W-1:0]  quotient;
   logic                         load_count;
   logic                         load_freq;
   ctnc_pkg::kmer_hit_type       hit;
   ctnc_pkg::store_cmd_type      store_cmd;
   ctnc_pkg::div_cmd_type        div_cmd;

   // Request handshake and beat decode.
   assign req_stall = (state_ff != ctnc_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign feed_acc  = accept && (req_kind == ctnc_pkg::KIND_FEED);
   assign read_acc  = accept && (req_kind == ctnc_pkg::KIND_READ);
   assign clear_acc = accept && (req_kind == ctnc_pkg::KIND_CLEAR);
   assign idx_ok    = (req_bin_index < 8'(ctnc_pkg::NUM_BINS));

   ctnc_kmer_front u_front (
      .clock     (clock),
      .reset     (reset),
      .feed      (feed_acc),
      .clear     (clear_acc),
      .base_char (req_base_char),
      .hit       (hit)
   );

   ctnc_bin_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .rd_data (rd_data)
   );

   ctnc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (quotient)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctnc_pkg::ST_IDLE: begin
            if (hit.hit) begin
               state_in = ctnc_pkg::ST_UPDATE;
            end else if (read_acc) begin
               state_in = ctnc_pkg::ST_FETCH;
            end
         end
         ctnc_pkg::ST_UPDATE:  state_in = ctnc_pkg::ST_IDLE;
         ctnc_pkg::ST_FETCH:   state_in = ctnc_pkg::ST_DIVIDE;
         ctnc_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = ctnc_pkg::ST_RESPOND;
            end
         end
         ctnc_pkg::ST_RESPOND: begin
            if (!rsp_stall) begin
               state_in = ctnc_pkg::ST_IDLE;
            end
         end
         default: state_in = ctnc_pkg::ST_IDLE;
      endcase
   end

   // The selected bin reads as zero when its index is out of range.
   assign fetch_count = idx_ok_ff ? rd_data : '0;

   // State outputs: store and divider commands, response loads, total.
   always_comb begin
      store_cmd         = '0;
      store_cmd.clear   = clear_acc;
      store_cmd.wr_addr = upd_addr_ff;
      store_cmd.wr_data = (rd_data == ctnc_pkg::COUNT_W'(ctnc_pkg::COUNT_MAX)) ?
                          rd_data : rd_data + 1'b1;
      div_cmd           = '0;
      div_cmd.numer     = fetch_count;
      div_cmd.denom     = total_ff;
      load_count        = 1'b0;
      load_freq         = 1'b0;
      total_in          = total_ff;
      case (state_ff)
         ctnc_pkg::ST_IDLE: begin
            store_cmd.rd_en   = hit.hit || (read_acc && idx_ok);
            store_cmd.rd_addr = hit.hit ? hit.bin :
                                req_bin_index[ctnc_pkg::BIN_AW-1:0];
            if (clear_acc) begin
               total_in = '0;
            end
         end
         ctnc_pkg::ST_UPDATE: begin
            store_cmd.wr_en = 1'b1;
            if (total_ff != ctnc_pkg::COUNT_W'(ctnc_pkg::COUNT_MAX)) begin
               total_in = total_ff + 1'b1;
            end
         end
         ctnc_pkg::ST_FETCH: begin
            div_cmd.start = 1'b1;
            load_count    = 1'b1;
         end
         ctnc_pkg::ST_DIVIDE: begin
            load_freq = div_done;
         end
         ctnc_pkg::ST_RESPOND: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctnc_pkg::ST_IDLE;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
      end
   end

   // Datapath registers: update address, index check and response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         upd_addr_ff <= hit.bin;
         idx_ok_ff   <= idx_ok;
      end
      if (load_count) begin
         rsp_count_ff <= fetch_count;
      end
      if (load_freq) begin
         rsp_freq_ff <= quotient;
      end
   end

   assign rsp_valid       = (state_ff == ctnc_pkg::ST_RESPOND);
   assign rsp_bin_count   = rsp_count_ff;
   assign rsp_total_kmers = total_ff;
   assign rsp_frequency   = rsp_freq_ff;

   // A write-back cycle always follows a completed 4-mer.
   a_update_after_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ctnc_pkg::ST_UPDATE) |-> $past(hit.hit))
      else $error("bin update without a completed 4-mer");

   // No request beat is taken while a response beat is pending.
   a_no_accept_on_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_valid)
      else $error("request accepted while a response is pending");

   // The total only holds, steps by one or clears.
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      (total_ff == $past(total_ff)) ||
      (total_ff == ctnc_pkg::COUNT_W'($past(total_ff) + 1'b1)) ||
      (total_ff == '0))
      else $error("total count jumped");

endmodule
